[design/rlt_pkg.sv]
// ----------------------------------------------------------------------------
// rlt_pkg
// Types and codes shared by the resonance and level tracker modules.
// ----------------------------------------------------------------------------
package rlt_pkg;

  // Request kinds on the input channel
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;

  // Settle wait requests
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_SHORT = 2'd1;
  localparam logic [1:0] REQ_LONG  = 2'd2;

  // Reported phase
  localparam logic [1:0] PHASE_OFF   = 2'd0;
  localparam logic [1:0] PHASE_IDLE  = 2'd1;
  localparam logic [1:0] PHASE_SWEEP = 2'd2;
  localparam logic [1:0] PHASE_BIAS  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FREQ_STEP  = 2'd0;
  localparam logic [1:0] CFG_MAX_OFFSET = 2'd1;
  localparam logic [1:0] CFG_BIAS_MIN   = 2'd2;
  localparam logic [1:0] CFG_BIAS_MAX   = 2'd3;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_CURRENT,
    MODE_AMP
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ACC,
    S_SWEEP,
    S_BIAS,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic mul;
    logic acc;
    logic sweep;
    logic bias;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       mode_on;
    logic       settled;
    logic       sweeping;
    logic       bias_stepping;
  } stat_t;

endpackage

[design/rlt_item_if.sv]
// ----------------------------------------------------------------------------
// rlt_item_if
// Input channel: sample, start and stop requests.
// ----------------------------------------------------------------------------
interface rlt_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              hold_amplitude;
  logic signed [10:0] meas_current;
  logic signed [10:0] meas_amp;
  logic              settled;
  logic [15:0]       load_freq;
  logic [7:0]        load_bias;

  modport source (
    output valid, kind, hold_amplitude, meas_current, meas_amp, settled,
           load_freq, load_bias,
    input  ready
  );
  modport sink (
    input  valid, kind, hold_amplitude, meas_current, meas_amp, settled,
           load_freq, load_bias,
    output ready
  );
endinterface

[design/rlt_result_if.sv]
// ----------------------------------------------------------------------------
// rlt_result_if
// Output channel: drive settings, settle request and phase.
// ----------------------------------------------------------------------------
interface rlt_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_freq;
  logic [7:0]  bias_pwm;
  logic [1:0]  settle_request;
  logic [1:0]  phase;

  modport source (
    output valid, drive_freq, bias_pwm, settle_request, phase,
    input  ready
  );
  modport sink (
    input  valid, drive_freq, bias_pwm, settle_request, phase,
    output ready
  );
endinterface

[design/rlt_cfg_if.sv]
// ----------------------------------------------------------------------------
// rlt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rlt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[design/rlt_ctrl.sv]
// ----------------------------------------------------------------------------
// rlt_ctrl
// Sequencer: walks each request through decode, then as needed through
// multiply-accumulate, sweep and bias steps; owns both channel handshakes.
// ----------------------------------------------------------------------------
module rlt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rlt_pkg::stat_t stat,
  output rlt_pkg::cmd_t  cmd
);

  rlt_pkg::state_t state, state_next;
  logic step_needed;
  logic out_free;

  assign step_needed = (stat.kind == rlt_pkg::KIND_SAMPLE) && stat.mode_on && stat.settled &&
                       (stat.sweeping || stat.bias_stepping);
  assign out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rlt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rlt_pkg::S_IDLE: begin
        if (in_valid) state_next = rlt_pkg::S_DECODE;
      end
      rlt_pkg::S_DECODE: begin
        if (!step_needed)       state_next = rlt_pkg::S_OUT;
        else if (stat.sweeping) state_next = rlt_pkg::S_MUL;
        else                    state_next = rlt_pkg::S_BIAS;
      end
      rlt_pkg::S_MUL:   state_next = rlt_pkg::S_ACC;
      rlt_pkg::S_ACC:   state_next = rlt_pkg::S_SWEEP;
      // a finished sweep may hand over to a bias step at once
      rlt_pkg::S_SWEEP: state_next = rlt_pkg::S_BIAS;
      rlt_pkg::S_BIAS:  state_next = rlt_pkg::S_OUT;
      rlt_pkg::S_OUT: begin
        if (out_free) state_next = rlt_pkg::S_IDLE;
      end
      default: state_next = rlt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      rlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rlt_pkg::S_DECODE: cmd.apply = !step_needed;
      rlt_pkg::S_MUL:    cmd.mul   = 1'b1;
      rlt_pkg::S_ACC:    cmd.acc   = 1'b1;
      rlt_pkg::S_SWEEP:  cmd.sweep = 1'b1;
      rlt_pkg::S_BIAS:   cmd.bias  = 1'b1;
      rlt_pkg::S_OUT:    cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

[design/rlt_dpath.sv]
// ----------------------------------------------------------------------------
// rlt_dpath
// Tracking state, configuration registers, sweep multiply-accumulate,
// correction clamp, bias stepper and the result register.
// ----------------------------------------------------------------------------
module rlt_dpath (
  input  logic               clk,
  input  logic               rst,
  input  rlt_pkg::cmd_t      cmd,
  output rlt_pkg::stat_t     stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         kind,
  input  logic               hold_amplitude,
  input  logic signed [10:0] meas_current,
  input  logic signed [10:0] meas_amp,
  input  logic               settled,
  input  logic [15:0]        load_freq,
  input  logic [7:0]         load_bias,
  output logic [15:0]        drive_freq,
  output logic [7:0]         bias_pwm,
  output logic [1:0]         settle_request,
  output logic [1:0]         phase
);

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    if (v[17])     return 16'd0;
    else if (v[16]) return 16'hFFFF;
    else           return v[15:0];
  endfunction

  // configuration
  logic [3:0] freq_step, max_offset;
  logic [7:0] bias_min, bias_max;

  // captured request
  logic [1:0]         kind_r;
  logic               hold_r;
  logic signed [10:0] cur_r, amp_r;
  logic               settled_r;
  logic [15:0]        load_freq_r;
  logic [7:0]         load_bias_r;

  // tracking state
  rlt_pkg::mode_t     mode;
  logic               sweeping, bias_stepping;
  logic signed [4:0]  offset;
  logic [3:0]         step_copy, bound_copy;
  logic [7:0]         lim;
  logic signed [8:0]  off_step;
  logic [15:0]        base_freq;
  logic signed [23:0] weighted_sum;
  logic               zero_run;
  logic signed [10:0] current_target, amp_target;
  logic [15:0]        freq_now;
  logic [7:0]         bias_now;
  logic signed [19:0] prod;
  logic               last_pt;
  logic [1:0]         req;

  // combinational helpers
  logic [7:0]         lim_cfg;
  logic signed [17:0] start_sum, fin_sum, step_sum;
  logic signed [23:0] lim_w;
  logic signed [8:0]  lim9, corr;
  logic               on_target, cur_low;
  logic signed [10:0] now_v, keep_v;

  assign lim_cfg   = {4'd0, freq_step} * {4'd0, max_offset};
  assign start_sum = $signed({2'b00, freq_now}) - $signed({10'd0, lim_cfg});
  assign lim_w     = $signed({16'd0, lim});
  assign lim9      = $signed({1'b0, lim});

  always_comb begin
    priority if (weighted_sum > lim_w)           corr = lim9;
    else if (weighted_sum < (24'sd0 - lim_w))    corr = 9'sd0 - lim9;
    else                                         corr = weighted_sum[8:0];
  end

  assign fin_sum  = $signed({2'b00, base_freq}) + $signed({{9{corr[8]}}, corr});
  assign step_sum = $signed({2'b00, base_freq}) + $signed({{9{off_step[8]}}, off_step});

  assign on_target = (cur_r == current_target) &&
                     ((amp_r == amp_target) || (mode == rlt_pkg::MODE_CURRENT));
  assign cur_low   = cur_r < current_target;
  assign now_v     = (mode == rlt_pkg::MODE_CURRENT) ? cur_r : amp_r;
  assign keep_v    = (mode == rlt_pkg::MODE_CURRENT) ? current_target : amp_target;

  assign stat.kind          = kind_r;
  assign stat.mode_on       = (mode != rlt_pkg::MODE_OFF);
  assign stat.settled       = settled_r;
  assign stat.sweeping      = sweeping;
  assign stat.bias_stepping = bias_stepping;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_step  <= 4'd1;
      max_offset <= 4'd5;
      bias_min   <= 8'd0;
      bias_max   <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlt_pkg::CFG_FREQ_STEP:  freq_step  <= cfg_data[3:0];
        rlt_pkg::CFG_MAX_OFFSET: max_offset <= cfg_data[3:0];
        rlt_pkg::CFG_BIAS_MIN:   bias_min   <= cfg_data;
        rlt_pkg::CFG_BIAS_MAX:   bias_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured request and sweep product carry no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r      <= kind;
      hold_r      <= hold_amplitude;
      cur_r       <= meas_current;
      amp_r       <= meas_amp;
      settled_r   <= settled;
      load_freq_r <= load_freq;
      load_bias_r <= load_bias;
    end
    if (cmd.mul) prod <= $signed({{9{cur_r[10]}}, cur_r}) *
                         $signed({{11{off_step[8]}}, off_step});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= rlt_pkg::MODE_OFF;
      sweeping       <= 1'b0;
      bias_stepping  <= 1'b0;
      offset         <= '0;
      step_copy      <= '0;
      bound_copy     <= '0;
      lim            <= '0;
      off_step       <= '0;
      base_freq      <= '0;
      weighted_sum   <= '0;
      zero_run       <= 1'b0;
      current_target <= '0;
      amp_target     <= '0;
      freq_now       <= '0;
      bias_now       <= '0;
      last_pt        <= 1'b0;
      req            <= rlt_pkg::REQ_NONE;
    end else begin
      if (cmd.load) req <= rlt_pkg::REQ_NONE;

      if (cmd.apply) begin
        priority case (kind_r)
          rlt_pkg::KIND_START: begin
            mode           <= hold_r ? rlt_pkg::MODE_AMP : rlt_pkg::MODE_CURRENT;
            current_target <= cur_r;
            amp_target     <= amp_r;
            freq_now       <= load_freq_r;
            bias_now       <= load_bias_r;
          end
          rlt_pkg::KIND_STOP: begin
            mode          <= rlt_pkg::MODE_OFF;
            sweeping      <= 1'b0;
            bias_stepping <= 1'b0;
          end
          rlt_pkg::KIND_SAMPLE: begin
            if (mode == rlt_pkg::MODE_OFF) begin
              sweeping      <= 1'b0;
              bias_stepping <= 1'b0;
            end else if (!sweeping && !bias_stepping && !on_target) begin
              if (cur_low) begin
                // open the sweep at the lowest offset
                sweeping     <= 1'b1;
                weighted_sum <= '0;
                base_freq    <= freq_now;
                bound_copy   <= max_offset;
                step_copy    <= freq_step;
                lim          <= lim_cfg;
                offset       <= 5'sd0 - $signed({1'b0, max_offset});
                off_step     <= 9'sd0 - $signed({1'b0, lim_cfg});
                freq_now     <= sat16(start_sum);
              end else begin
                bias_stepping <= 1'b1;
              end
              req <= rlt_pkg::REQ_SHORT;
            end
          end
          default: ;
        endcase
      end

      if (cmd.acc) begin
        weighted_sum <= weighted_sum + {{4{prod[19]}}, prod};
        last_pt      <= (offset == $signed({1'b0, bound_copy}));
        if (offset != $signed({1'b0, bound_copy})) begin
          offset   <= offset + 5'sd1;
          off_step <= off_step + $signed({5'd0, step_copy});
        end
      end

      if (cmd.sweep) begin
        if (last_pt) begin
          freq_now <= sat16(fin_sum);
          sweeping <= 1'b0;
          if (corr != 9'sd0) begin
            zero_run <= 1'b0;
          end else if (zero_run) begin
            // second zero correction in a row: go trim the bias
            zero_run      <= 1'b0;
            bias_stepping <= 1'b1;
          end else begin
            zero_run <= 1'b1;
          end
        end else begin
          freq_now <= sat16(step_sum);
          req      <= rlt_pkg::REQ_SHORT;
        end
      end

      if (cmd.bias && bias_stepping) begin
        if ((now_v < keep_v) && (bias_now < bias_max)) begin
          bias_now <= bias_now + 8'd1;
          req      <= rlt_pkg::REQ_LONG;
        end else if ((now_v > keep_v) && (bias_now > bias_min)) begin
          bias_now <= bias_now - 8'd1;
          req      <= rlt_pkg::REQ_LONG;
        end else begin
          bias_stepping  <= 1'b0;
          current_target <= cur_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive_freq     <= freq_now;
      bias_pwm       <= bias_now;
      settle_request <= req;
      if (mode == rlt_pkg::MODE_OFF) phase <= rlt_pkg::PHASE_OFF;
      else if (bias_stepping)        phase <= rlt_pkg::PHASE_BIAS;
      else if (sweeping)             phase <= rlt_pkg::PHASE_SWEEP;
      else                           phase <= rlt_pkg::PHASE_IDLE;
    end
  end

endmodule

[design/resonance_and_level_tracker.sv]
// ----------------------------------------------------------------------------
// resonance_and_level_tracker
// Resonance and drive level tracker for an ultrasonic generator.
// ----------------------------------------------------------------------------
// One result leaves for every request taken. A request is taken in the idle
// state and passes through decode and then the output state before the
// sequencer returns to idle: start, stop and plain samples take only these,
// a bias step adds the bias state, and a settled sample during a frequency
// sweep adds the multiply, accumulate, sweep and bias states, for the
// registered multiply and accumulate of current times offset, the correction
// clamp and the bias step that can follow a finished sweep. The output
// register lets the next request in while a result waits; the sequencer only
// stalls when a new result is ready and the previous one has not been taken.
// Configuration writes are accepted in every cycle and belong to quiet periods.
module resonance_and_level_tracker (
  input  logic          clk,
  input  logic          rst,
  rlt_item_if.sink      item,
  rlt_result_if.source  result,
  rlt_cfg_if.sink       cfg
);

  rlt_pkg::cmd_t  cmd;
  rlt_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlt_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .kind           (item.kind),
    .hold_amplitude (item.hold_amplitude),
    .meas_current   (item.meas_current),
    .meas_amp       (item.meas_amp),
    .settled        (item.settled),
    .load_freq      (item.load_freq),
    .load_bias      (item.load_bias),
    .drive_freq     (result.drive_freq),
    .bias_pwm       (result.bias_pwm),
    .settle_request (result.settle_request),
    .phase          (result.phase)
  );

endmodule

[design/rlt_checker.sv]
// ----------------------------------------------------------------------------
// rlt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] drive_freq,
  input logic [7:0]  bias_pwm,
  input logic [1:0]  settle_request,
  input logic [1:0]  phase
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_freq) && $stable(bias_pwm) &&
                                $stable(settle_request) && $stable(phase))
    else $error("result changed while stalled");

  // one request at a time through the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in back-to-back cycles");

  // tracking off never asks for a settle wait
  a_off_no_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == rlt_pkg::PHASE_OFF) |-> settle_request == rlt_pkg::REQ_NONE)
    else $error("settle wait requested while tracking is off");

  // a long wait only comes from a bias step still in progress
  a_long_bias: assert property (@(posedge clk) disable iff (rst)
    out_valid && (settle_request == rlt_pkg::REQ_LONG) |-> phase == rlt_pkg::PHASE_BIAS)
    else $error("long wait outside bias stepping");

  // a short wait starts or continues a search
  a_short_search: assert property (@(posedge clk) disable iff (rst)
    out_valid && (settle_request == rlt_pkg::REQ_SHORT) |->
      (phase == rlt_pkg::PHASE_SWEEP) || (phase == rlt_pkg::PHASE_BIAS))
    else $error("short wait outside a search");

endmodule

bind resonance_and_level_tracker rlt_checker u_rlt_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .drive_freq     (result.drive_freq),
  .bias_pwm       (result.bias_pwm),
  .settle_request (result.settle_request),
  .phase          (result.phase)
);
